[design/schc_pkg.sv]
// Package for the self-calibrating hysteresis comparator.
// Holds field widths, limits, register and mode codes and the shared structs.
// Used by schc_step and by self_calibrating_hysteresis_comparator_core.
`timescale 1ns / 1ps

package schc_pkg;

   localparam int SAMPLE_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
   localparam logic [SAMPLE_W-1:0] MIN_GAP = 10'd5;
   localparam logic [SAMPLE_W-1:0] HALF_BAND_RESET = 10'd40;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BAND_FIXED = 2'd2;

   // Dead band modes. The unused code falls back to the minimum mode.
   localparam logic [1:0] DB_FIXED = 2'd0;
   localparam logic [1:0] DB_QUARTER = 2'd1;
   localparam logic [1:0] DB_MIN = 2'd2;

   typedef struct packed {
      logic                calibrate_enable;
      logic [1:0]          deadband_mode;
      logic [SAMPLE_W-1:0] half_band_fixed;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] range_low;
      logic [SAMPLE_W-1:0] range_high;
      logic [SAMPLE_W-1:0] thresh_low;
      logic [SAMPLE_W-1:0] thresh_high;
      logic                level;
   } cal_state_type;

endpackage

[design/schc_step.sv]
// Next-state logic of the comparator for one sample: range tracking,
// threshold recalculation and the hysteresis decision.
// Depends on schc_pkg.
`timescale 1ns / 1ps

module schc_step (
   input  schc_pkg::cfg_type                 cfg,
   input  logic [schc_pkg::SAMPLE_W-1:0]     sample,
   input  schc_pkg::cal_state_type           state_cur,
   output schc_pkg::cal_state_type           state_nxt
);
   import schc_pkg::*;

   logic                lt_low;
   logic                gt_high;
   logic                changed;
   logic [SAMPLE_W-1:0] low_new;
   logic [SAMPLE_W-1:0] high_new;
   logic [SAMPLE_W-1:0] extent;
   logic [SAMPLE_W-1:0] quarter;
   logic [SAMPLE_W-1:0] half;
   logic [SAMPLE_W:0]   sum;
   logic [SAMPLE_W-1:0] mid;
   logic [SAMPLE_W:0]   up;
   logic [SAMPLE_W-1:0] tl_new;
   logic [SAMPLE_W-1:0] th_new;
   logic [SAMPLE_W-1:0] tl;
   logic [SAMPLE_W-1:0] th;
   logic                gap_ok;

   always_comb begin
      lt_low = sample < state_cur.range_low;
      gt_high = sample > state_cur.range_high;
      changed = cfg.calibrate_enable && (lt_low || gt_high);
      low_new = (cfg.calibrate_enable && lt_low) ? sample : state_cur.range_low;
      high_new = (cfg.calibrate_enable && gt_high) ? sample : state_cur.range_high;

      extent = (high_new >= low_new) ? (high_new - low_new) : '0;
      quarter = extent >> 2;
      unique case (cfg.deadband_mode)
         DB_FIXED:   half = cfg.half_band_fixed;
         DB_QUARTER: half = quarter;
         default:    half = (quarter < cfg.half_band_fixed) ? quarter : cfg.half_band_fixed;
      endcase

      sum = {1'b0, low_new} + {1'b0, high_new};
      mid = sum[SAMPLE_W:1];
      up = {1'b0, mid} + {1'b0, half};
      // The lower threshold saturates at zero instead of wrapping.
      tl_new = (mid >= half) ? (mid - half) : '0;
      th_new = (up > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : up[SAMPLE_W-1:0];

      tl = changed ? tl_new : state_cur.thresh_low;
      th = changed ? th_new : state_cur.thresh_high;

      // A negative or narrow gap freezes the level; this covers the reset state.
      gap_ok = (th >= tl) && ((th - tl) >= MIN_GAP);

      state_nxt.range_low = low_new;
      state_nxt.range_high = high_new;
      state_nxt.thresh_low = tl;
      state_nxt.thresh_high = th;
      if (!gap_ok) begin
         state_nxt.level = state_cur.level;
      end else if (state_cur.level) begin
         state_nxt.level = !(sample < tl);
      end else begin
         state_nxt.level = sample > th;
      end
   end

endmodule

[design/self_calibrating_hysteresis_comparator_core.sv]
// Self-calibrating hysteresis comparator: one level beat per sample beat.
// A sample accepted into the input stage passes to the output register, which drives rsp_.
// Throughput: one sample per cycle while rsp_tready is high; a stalled output holds the flow.
// The output register and the input stage let a new beat in while a result waits.
// Synchronous active-high reset restores the register defaults, an empty range
// (low 1023, high 0), thresholds 1023/0 and a high level.
`timescale 1ns / 1ps

module self_calibrating_hysteresis_comparator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [schc_pkg::REQ_DATA_W-1:0]    req_tdata,   // [9:0] sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [schc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [0] level
   input  logic                               csr_we,
   input  logic [schc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [schc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import schc_pkg::*;

   cfg_type             cfg_ff;
   cal_state_type       state_ff;
   cal_state_type       state_in;
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                rsp_valid_ff;
   logic                rsp_level_ff;
   logic                advance;

   // The staged sample moves into the output register when that register is free.
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, rsp_level_ff};

   schc_step u_step (
      .cfg       (cfg_ff),
      .sample    (in_sample_ff),
      .state_cur (state_ff),
      .state_nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calibrate_enable <= 1'b1;
         cfg_ff.deadband_mode <= DB_MIN;
         cfg_ff.half_band_fixed <= HALF_BAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CALIBRATE_ENABLE: cfg_ff.calibrate_enable <= csr_wdata[0];
            CSR_DEADBAND_MODE:    cfg_ff.deadband_mode <= csr_wdata[1:0];
            CSR_HALF_BAND_FIXED:  cfg_ff.half_band_fixed <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.range_low <= SAMPLE_MAX;
         state_ff.range_high <= '0;
         state_ff.thresh_low <= SAMPLE_MAX;
         state_ff.thresh_high <= '0;
         state_ff.level <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (advance) begin
         rsp_level_ff <= state_in.level;
      end
   end

endmodule

[verif/self_calibrating_hysteresis_comparator_core_tb.sv]
// Self-checking testbench for self_calibrating_hysteresis_comparator_core.
// Predicts each level beat from its own model of the range tracking and hysteresis;
// depends on schc_pkg and the core RTL only.
`timescale 1ns / 1ps

module self_calibrating_hysteresis_comparator_core_tb;
   import schc_pkg::*;

   localparam logic [1:0] DB_UNUSED = 2'd3;
   localparam int TRACK_PHASE_ITEMS = 380;
   localparam int FROZEN_PHASE_ITEMS = 90;
   localparam int PRESSURE_ITEMS = 30;
   localparam int TRACK_TOTAL = 4 * TRACK_PHASE_ITEMS + PRESSURE_ITEMS;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [9:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [0] level
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the registers and the calibration state.
   cfg_type             shadow_cfg = '{1'b1, DB_MIN, HALF_BAND_RESET};
   logic [SAMPLE_W-1:0] seen_low = SAMPLE_MAX;
   logic [SAMPLE_W-1:0] seen_high = '0;
   logic [SAMPLE_W-1:0] trip_low = SAMPLE_MAX;
   logic [SAMPLE_W-1:0] trip_high = '0;
   logic                level_now = 1'b1;

   logic level_queue[$];
   int   mismatch_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_request = 0;
   int   hold_left = 0;
   int   tracked_items = 0;

   self_calibrating_hysteresis_comparator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic predict_level(input logic [SAMPLE_W-1:0] s);
      logic                changed;
      logic [SAMPLE_W-1:0] extent;
      logic [SAMPLE_W-1:0] quarter;
      logic [SAMPLE_W-1:0] half;
      logic [SAMPLE_W-1:0] mid;
      logic [SAMPLE_W:0]   total;
      logic [SAMPLE_W:0]   upper;
      int                  gap;
      changed = 1'b0;
      if (shadow_cfg.calibrate_enable) begin
         if (s < seen_low) begin
            seen_low = s;
            changed = 1'b1;
         end
         if (s > seen_high) begin
            seen_high = s;
            changed = 1'b1;
         end
         if (changed) begin
            extent = (seen_high >= seen_low) ? seen_high - seen_low : '0;
            quarter = extent >> 2;
            case (shadow_cfg.deadband_mode)
               DB_FIXED: half = shadow_cfg.half_band_fixed;
               DB_QUARTER: half = quarter;
               default: begin
                  half = (quarter < shadow_cfg.half_band_fixed) ? quarter
                                                                : shadow_cfg.half_band_fixed;
               end
            endcase
            total = {1'b0, seen_low} + {1'b0, seen_high};
            mid = total[SAMPLE_W:1];
            upper = {1'b0, mid} + {1'b0, half};
            trip_low = (mid >= half) ? mid - half : '0;
            trip_high = (upper > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : upper[SAMPLE_W-1:0];
         end
      end
      // A negative or narrow gap, as right after reset, freezes the level.
      gap = int'(trip_high) - int'(trip_low);
      if (gap >= int'(MIN_GAP)) begin
         if (level_now && s < trip_low) begin
            level_now = 1'b0;
         end else if (!level_now && s > trip_high) begin
            level_now = 1'b1;
         end
      end
      return level_now;
   endfunction

   // Result side: checks every level beat and drives the stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_queue.size() == 0) begin
            $display("%0t: unexpected level beat, expected none, got %0b", $time,
                     rsp_tdata[0]);
            mismatch_count++;
         end else if (rsp_tdata[0] !== level_queue[0]) begin
            $display("%0t: level mismatch, expected %0b, got %0b", $time, level_queue[0],
                     rsp_tdata[0]);
            mismatch_count++;
            void'(level_queue.pop_front());
         end else begin
            void'(level_queue.pop_front());
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-SAMPLE_W){1'b0}}, s};
      do @(posedge clock); while (!req_tready);
      level_queue.push_back(predict_level(s));
   endtask

   // Leaves the block idle with every pending level delivered.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (level_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CALIBRATE_ENABLE: shadow_cfg.calibrate_enable = value[0];
         CSR_DEADBAND_MODE: shadow_cfg.deadband_mode = value[1:0];
         CSR_HALF_BAND_FIXED: shadow_cfg.half_band_fixed = value[SAMPLE_W-1:0];
         default: ;
      endcase
   endtask

   // Samples spread around mid scale in a window that widens over the run, so the
   // tracked range keeps growing and the thresholds keep moving.
   task automatic run_tracking(input int count);
      int span;
      int value;
      for (int i = 0; i < count; i++) begin
         span = 8 + (tracked_items * 504) / TRACK_TOTAL;
         value = 512 - span + int'($urandom_range(2 * span));
         if (value < 0) value = 0;
         if (value > int'(SAMPLE_MAX)) value = int'(SAMPLE_MAX);
         send_sample(value[SAMPLE_W-1:0]);
         tracked_items++;
      end
   endtask

   task automatic run_frozen(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick == 0) send_sample('0);
         else if (pick == 1) send_sample(SAMPLE_MAX);
         else send_sample(SAMPLE_W'($urandom_range(int'(SAMPLE_MAX))));
      end
   endtask

   // With calibration off from reset, the thresholds stay at 1023/0 and the level
   // must hold high even for the extreme samples.
   task automatic test_frozen_after_reset();
      write_reg(CSR_CALIBRATE_ENABLE, 10'd0);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(10'd512);
      send_sample(10'd1);
      drain();
      write_reg(CSR_CALIBRATE_ENABLE, 10'd1);
   endtask

   task automatic test_range_tracking();
      send_sample(10'd500);
      send_sample(10'd500);
      send_sample(10'd503);
      send_sample(10'd497);
      send_sample(10'd520);
      send_sample(10'd490);
      send_sample(10'd513);
      send_sample(10'd489);
      drain();
   endtask

   // Each sample widens the range so the new band setting takes effect.
   task automatic test_band_modes();
      write_reg(CSR_DEADBAND_MODE, {8'd0, DB_FIXED});
      write_reg(CSR_HALF_BAND_FIXED, 10'd0);
      send_sample(10'd521);
      drain();
      // A full-scale half band drives the lower threshold down to its zero floor.
      write_reg(CSR_HALF_BAND_FIXED, 10'd1023);
      send_sample(10'd488);
      send_sample(10'd480);
      drain();
      write_reg(CSR_DEADBAND_MODE, {8'd0, DB_QUARTER});
      send_sample(10'd522);
      drain();
      write_reg(CSR_DEADBAND_MODE, {8'd0, DB_UNUSED});
      write_reg(CSR_HALF_BAND_FIXED, 10'd3);
      send_sample(10'd478);
      send_sample(10'd524);
      drain();
      write_reg(CSR_DEADBAND_MODE, {8'd0, DB_MIN});
      write_reg(CSR_HALF_BAND_FIXED, HALF_BAND_RESET);
      send_sample(10'd525);
      drain();
   endtask

   // The receiver holds off long enough for the block to fill and refuse input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 60;
      run_tracking(PRESSURE_ITEMS);
      drain();
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               write_reg(CSR_DEADBAND_MODE, {8'd0, DB_MIN});
               write_reg(CSR_HALF_BAND_FIXED, HALF_BAND_RESET);
            end
            1: begin
               send_idle_pct = 50;
               recv_stall_pct = 0;
               write_reg(CSR_DEADBAND_MODE, {8'd0, DB_QUARTER});
               write_reg(CSR_HALF_BAND_FIXED, CSR_DATA_W'($urandom_range(1023)));
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 50;
               write_reg(CSR_DEADBAND_MODE, {8'd0, DB_FIXED});
               write_reg(CSR_HALF_BAND_FIXED, CSR_DATA_W'($urandom_range(60)));
            end
            default: begin
               send_idle_pct = 8;
               recv_stall_pct = 8;
               write_reg(CSR_DEADBAND_MODE, {8'd0, DB_UNUSED});
               write_reg(CSR_HALF_BAND_FIXED, CSR_DATA_W'($urandom_range(1, 30)));
            end
         endcase
         run_tracking(TRACK_PHASE_ITEMS);
         drain();
         write_reg(CSR_CALIBRATE_ENABLE, 10'd0);
         run_frozen(FROZEN_PHASE_ITEMS);
         drain();
         write_reg(CSR_CALIBRATE_ENABLE, 10'd1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frozen_after_reset();
      test_range_tracking();
      test_band_modes();
      test_backpressure();
      test_random_phases();
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
